[sv/plm_pkg.sv]
`default_nettype none
package plm_pkg;

  localparam int SMP_W  = 14;
  localparam int PER_W  = 20;
  localparam int TH_W   = 19;
  localparam int DIV_W  = 39;
  localparam int DIVV_W = 19;
  localparam int MUL_W  = 20;
  localparam int PROD_W = 40;
  localparam int ZC_W   = 13;
  localparam int T_W    = 32;
  localparam int MV_W   = 16;

  localparam logic [15:0] ZERO_OFF = 16'hFFFF;
  localparam logic [MV_W-1:0] MV_MAX = 16'hFFFF;
  localparam logic [T_W-1:0] T_MAX = 32'hFFFF_FFFF;
  localparam logic [MUL_W-1:0] AMP_NUM = 20'd96;
  localparam logic [DIVV_W-1:0] AMP_DEN = 19'd100;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             frame_valid;
    logic             rise_valid;
    logic [ZC_W-1:0]  zero_count;
    logic [SMP_W-1:0] low_level;
    logic [SMP_W-1:0] high_level;
    logic [SMP_W-1:0] amplitude;
    logic [MV_W-1:0]  amplitude_mv;
    logic [T_W-1:0]   t10_ps;
    logic [T_W-1:0]   t90_ps;
    logic [T_W-1:0]   rise_ps;
  } out_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_ZEROS   = 3'd2,
    ST_NOLEVEL = 3'd3,
    ST_SMALL   = 3'd4,
    ST_OVER    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    REG_PERIOD   = 3'd0,
    REG_FS       = 3'd1,
    REG_ADC_MAX  = 3'd2,
    REG_LEVEL    = 3'd3,
    REG_ZLIMIT   = 3'd4,
    REG_MIN_AMP  = 3'd5,
    REG_GUARD    = 3'd6,
    REG_MIN_SPAN = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_LOAD, S_CHECK, S_REPAIR, S_LVL, S_SUM, S_DLOW, S_DHIGH, S_MAMP, S_DAMP,
    S_MMV, S_DMV, S_EVAL, S_SCAN, S_MFRAC, S_DFRAC, S_MIDX, S_TADD, S_RISE,
    S_RESULT
  } state_t;

endpackage
`default_nettype wire

[sv/plm_store.sv]
`default_nettype none
module plm_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 14
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[sv/plm_div.sv]
`default_nettype none
module plm_div #(
  parameter int DW = 39,
  parameter int VW = 19
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic      [DW-1:0] quotient
);

  localparam int CNW = $clog2(DW + 1);

  logic [VW:0]    rem_r, rem_nxt;
  logic [DW-1:0]  quo_r, quo_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [VW:0]    rem_sh;
  logic [VW+1:0]  trial;

  always_comb begin
    rem_sh   = {rem_r[VW-1:0], quo_r[DW-1]};
    trial    = {1'b0, rem_sh} - {2'b00, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[VW+1]) begin
        rem_nxt = trial[VW:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

[sv/plm_rank.sv]
`default_nettype none
module plm_rank #(
  parameter int   K_MAX = 8,
  parameter logic SMALL = 1'b1,
  parameter int   KW    = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clear,
  input  wire logic          ins,
  input  wire logic          shift,
  input  wire logic [KW-1:0] k,
  input  wire logic [13:0]   v,
  output logic      [13:0]   head,
  output logic      [KW-1:0] fill
);

  logic [13:0]      list_r   [K_MAX];
  logic [13:0]      list_nxt [K_MAX];
  logic [KW-1:0]    fill_r, fill_nxt;
  logic [K_MAX-1:0] lt;
  logic [K_MAX-1:0] lt_prev;

  // lt marks entries that the new code beats; entries are kept sorted
  always_comb begin
    for (int j = 0; j < K_MAX; j++) begin
      lt[j] = (KW'(j) < fill_r) && (SMALL ? (v < list_r[j]) : (v > list_r[j]));
    end
    lt_prev = lt << 1;
    for (int j = 0; j < K_MAX; j++) begin
      list_nxt[j] = list_r[j];
      if (shift) begin
        if (j < K_MAX - 1) begin
          list_nxt[j] = list_r[j+1];
        end
      end else if (ins && (KW'(j) < k)) begin
        if (lt_prev[j] && (j > 0)) begin
          list_nxt[j] = list_r[j-1];
        end else if (lt[j] || (KW'(j) == fill_r)) begin
          list_nxt[j] = v;
        end
      end
    end
    fill_nxt = fill_r;
    if (clear) begin
      fill_nxt = '0;
    end else if (ins && (fill_r < k)) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
    for (int j = 0; j < K_MAX; j++) begin
      list_r[j] <= list_nxt[j];
    end
  end

  assign head = list_r[0];
  assign fill = fill_r;

endmodule
`default_nettype wire

[sv/pulse_level_and_rise_time_measure.sv]
`default_nettype none
// channel   handshake                  payload
// in_       in_valid / in_stall        in_data  (sample, last)
// out_      out_valid / out_stall      out_data (status ... rise_ps)
// apb       psel penable pwrite pready paddr pwdata prdata
// samples load one per cycle in the load state; the result follows last after the
// analysis, whose time is set by the frame length (n), the level count, the
// three passes over the sample store's single read port and the serial divider
// no item is taken during analysis; a waiting result does not hold loading
// rst_n is synchronous; control and configuration registers return to their listed defaults
module pulse_level_and_rise_time_measure #(
  parameter int MAX_SAMPLES     = 4096,
  parameter int MAX_LEVEL_COUNT = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire plm_pkg::in_t         in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output plm_pkg::out_t             out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);

  localparam int AW   = $clog2(MAX_SAMPLES);
  localparam int LW   = $clog2(MAX_SAMPLES + 1);
  localparam int CW   = $clog2(MAX_SAMPLES + 2);
  localparam int KW   = $clog2(MAX_LEVEL_COUNT + 1);
  localparam int SUMW = plm_pkg::SMP_W + KW;
  localparam int THW  = plm_pkg::TH_W;

  // configuration
  logic [19:0] period_r;
  logic [13:0] fs_r, adc_r, mina_r;
  logic [3:0]  lvl_r;
  logic [15:0] zlim_r;
  logic [10:0] eg_r;
  logic [12:0] mrs_r;
  logic        cfg_wr;

  plm_pkg::state_t  state_r, state_nxt;
  plm_pkg::status_t status_r;

  logic [LW-1:0]  n_r, tally_r, drops_r, seg_r, c10_r, c90_r;
  logic           ovf_r, ph_r, have_r, rise_r, div_sent_r;
  logic [CW-1:0]  c_r;
  logic [1:0]     warm_r;
  logic [13:0]    x_r, y_r, low_r, high_r, amp_r;
  logic [THW-1:0] diff_r, den_r;
  logic [KW-1:0]  cnt_r;
  logic [SUMW-1:0] lsum_r, hsum_r;
  logic [15:0]    mv_r;
  logic [31:0]    t10_r, t90_r;
  logic [plm_pkg::DIV_W-1:0]  frac_r;
  logic [plm_pkg::PROD_W-1:0] mul_r;
  logic [plm_pkg::ZC_W-1:0]   zc_r;
  logic           out_valid_r;
  plm_pkg::out_t  out_r, out_nxt;

  // shared units
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [13:0]                  mem_wdata, rd;
  logic                         div_start, div_done, div_state;
  logic [plm_pkg::DIV_W-1:0]    div_a, div_q;
  logic [plm_pkg::DIVV_W-1:0]   div_b;
  logic [plm_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic                         rk_clear, rk_ins, rk_shift;
  logic [13:0]                  s_head, l_head;
  logic [KW-1:0]                s_fill, l_fill;

  // pass helpers
  logic           in_acc, has_room, out_free;
  logic [CW-1:0]  j_idx;
  logic           rp_go, rp_fix, rp_end;
  logic [14:0]    rp_sum;
  logic [13:0]    rp_v;
  logic [THW-1:0] th, ten0, ten1;
  logic           hit, scan_end;
  logic [40:0]    tsum;
  logic [31:0]    tsat;
  logic           lvl_bad, rise_ok, edge_ok;
  logic [LW:0]    span;

  assign in_acc   = in_valid && !in_stall;
  assign has_room = n_r < LW'(MAX_SAMPLES);
  assign out_free = !out_valid_r || !out_stall;
  assign lvl_bad  = 32'(lvl_r) > 32'(MAX_LEVEL_COUNT);
  assign cfg_wr   = psel && penable && pwrite && pready;

  // isolated zero repair over a three-sample window
  assign j_idx  = c_r - CW'(2);
  assign rp_go  = c_r >= CW'(2);
  assign rp_fix = rp_go && (y_r == '0) && (j_idx >= CW'(1)) &&
                  ((j_idx + CW'(1)) < CW'(n_r)) && (x_r != '0) && (rd != '0);
  assign rp_sum = {1'b0, x_r} + {1'b0, rd};
  assign rp_v   = rp_fix ? rp_sum[14:1] : y_r;
  assign rp_end = c_r == (CW'(n_r) + CW'(1));

  // crossing search, thresholds in tenths of a code
  assign th   = ph_r ? (THW'(low_r) * THW'(10) + THW'(amp_r) * THW'(9))
                     : (THW'(low_r) * THW'(10) + THW'(amp_r));
  assign ten0 = THW'(y_r) * THW'(10);
  assign ten1 = THW'(rd) * THW'(10);
  assign hit  = (warm_r == 2'd2) && (y_r != '0) && (rd != '0) && (rd > y_r) &&
                (ten0 <= th) && (ten1 >= th);
  assign scan_end = (warm_r == 2'd2) && (c_r == CW'(n_r));

  assign tsum = 41'(mul_r) + 41'(frac_r);
  assign tsat = (tsum > 41'(plm_pkg::T_MAX)) ? plm_pkg::T_MAX : tsum[31:0];

  assign span    = {1'b0, c90_r} - {1'b0, c10_r} + (LW+1)'(1);
  assign edge_ok = (32'(c10_r) >= 32'(eg_r)) &&
                   (32'(c90_r) < (32'(n_r) - 32'(eg_r) - 32'd1)) && (c90_r > c10_r);
  assign rise_ok = edge_ok && (32'(span) >= 32'(mrs_r)) &&
                   ({1'b0, drops_r} <= (span >> 2)) && (t90_r > t10_r);

  assign div_state = (state_r == plm_pkg::S_DLOW) || (state_r == plm_pkg::S_DHIGH) ||
                     (state_r == plm_pkg::S_DAMP) || (state_r == plm_pkg::S_DMV) ||
                     (state_r == plm_pkg::S_DFRAC);

  plm_store #(.DEPTH(MAX_SAMPLES), .AW(AW), .DW(14)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (c_r[AW-1:0]),
    .rdata (rd)
  );

  plm_div #(.DW(plm_pkg::DIV_W), .VW(plm_pkg::DIVV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  plm_rank #(.K_MAX(MAX_LEVEL_COUNT), .SMALL(1'b1), .KW(KW)) u_small (
    .clk (clk), .rst_n (rst_n), .clear (rk_clear), .ins (rk_ins), .shift (rk_shift),
    .k (KW'(lvl_r)), .v (rp_v), .head (s_head), .fill (s_fill)
  );

  plm_rank #(.K_MAX(MAX_LEVEL_COUNT), .SMALL(1'b0), .KW(KW)) u_large (
    .clk (clk), .rst_n (rst_n), .clear (rk_clear), .ins (rk_ins), .shift (rk_shift),
    .k (KW'(lvl_r)), .v (rp_v), .head (l_head), .fill (l_fill)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plm_pkg::S_LOAD:   if (in_acc && in_data.last) state_nxt = plm_pkg::S_CHECK;
      plm_pkg::S_CHECK: begin
        if (ovf_r || (n_r < LW'(2))) begin
          state_nxt = plm_pkg::S_RESULT;
        end else if ((zlim_r != plm_pkg::ZERO_OFF) && (32'(tally_r) > 32'(zlim_r))) begin
          state_nxt = plm_pkg::S_RESULT;
        end else begin
          state_nxt = plm_pkg::S_REPAIR;
        end
      end
      plm_pkg::S_REPAIR: if (rp_end) state_nxt = plm_pkg::S_LVL;
      plm_pkg::S_LVL:    state_nxt = (lvl_bad || (s_fill == '0)) ? plm_pkg::S_RESULT
                                                                  : plm_pkg::S_SUM;
      plm_pkg::S_SUM:    if (cnt_r == s_fill) state_nxt = plm_pkg::S_DLOW;
      plm_pkg::S_DLOW:   if (div_done) state_nxt = plm_pkg::S_DHIGH;
      plm_pkg::S_DHIGH: begin
        if (div_done) begin
          state_nxt = (div_q[13:0] <= low_r) ? plm_pkg::S_RESULT : plm_pkg::S_MAMP;
        end
      end
      plm_pkg::S_MAMP:   state_nxt = plm_pkg::S_DAMP;
      plm_pkg::S_DAMP:   if (div_done) state_nxt = plm_pkg::S_MMV;
      plm_pkg::S_MMV:    state_nxt = (adc_r == '0) ? plm_pkg::S_EVAL : plm_pkg::S_DMV;
      plm_pkg::S_DMV:    if (div_done) state_nxt = plm_pkg::S_EVAL;
      plm_pkg::S_EVAL: begin
        if ((amp_r >= mina_r) && (period_r != '0) &&
            (32'(n_r) > (32'(eg_r) * 32'd2 + 32'd2))) begin
          state_nxt = plm_pkg::S_SCAN;
        end else begin
          state_nxt = plm_pkg::S_RESULT;
        end
      end
      plm_pkg::S_SCAN: begin
        if (hit) begin
          state_nxt = plm_pkg::S_MFRAC;
        end else if (scan_end) begin
          state_nxt = plm_pkg::S_RESULT;
        end
      end
      plm_pkg::S_MFRAC:  state_nxt = plm_pkg::S_DFRAC;
      plm_pkg::S_DFRAC:  if (div_done) state_nxt = plm_pkg::S_MIDX;
      plm_pkg::S_MIDX:   state_nxt = plm_pkg::S_TADD;
      plm_pkg::S_TADD:   state_nxt = ph_r ? plm_pkg::S_RISE : plm_pkg::S_SCAN;
      plm_pkg::S_RISE:   state_nxt = plm_pkg::S_RESULT;
      plm_pkg::S_RESULT: if (out_free) state_nxt = plm_pkg::S_LOAD;
      default:           state_nxt = plm_pkg::S_LOAD;
    endcase
  end

  // unit controls
  always_comb begin
    in_stall  = state_r != plm_pkg::S_LOAD;
    mem_we    = 1'b0;
    mem_waddr = n_r[AW-1:0];
    mem_wdata = in_data.sample;
    rk_clear  = state_r == plm_pkg::S_CHECK;
    rk_ins    = 1'b0;
    rk_shift  = 1'b0;
    div_start = div_state && !div_sent_r;
    div_a     = '0;
    div_b     = '0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      plm_pkg::S_LOAD: mem_we = in_acc && has_room;
      plm_pkg::S_REPAIR: begin
        mem_we    = rp_fix;
        mem_waddr = j_idx[AW-1:0];
        mem_wdata = rp_v;
        rk_ins    = rp_go && (rp_v != '0);
      end
      plm_pkg::S_SUM:  rk_shift = cnt_r != s_fill;
      plm_pkg::S_DLOW: begin
        div_a = plm_pkg::DIV_W'(lsum_r);
        div_b = plm_pkg::DIVV_W'(s_fill);
      end
      plm_pkg::S_DHIGH: begin
        div_a = plm_pkg::DIV_W'(hsum_r);
        div_b = plm_pkg::DIVV_W'(l_fill);
      end
      plm_pkg::S_MAMP: begin
        mul_a = plm_pkg::MUL_W'(high_r - low_r);
        mul_b = plm_pkg::AMP_NUM;
      end
      plm_pkg::S_DAMP: begin
        div_a = mul_r[plm_pkg::DIV_W-1:0];
        div_b = plm_pkg::AMP_DEN;
      end
      plm_pkg::S_MMV: begin
        mul_a = plm_pkg::MUL_W'(amp_r);
        mul_b = plm_pkg::MUL_W'(fs_r);
      end
      plm_pkg::S_DMV: begin
        div_a = mul_r[plm_pkg::DIV_W-1:0];
        div_b = plm_pkg::DIVV_W'(adc_r);
      end
      plm_pkg::S_MFRAC: begin
        mul_a = plm_pkg::MUL_W'(diff_r);
        mul_b = period_r;
      end
      plm_pkg::S_DFRAC: begin
        div_a = mul_r[plm_pkg::DIV_W-1:0];
        div_b = den_r;
      end
      plm_pkg::S_MIDX: begin
        mul_a = plm_pkg::MUL_W'(seg_r);
        mul_b = period_r;
      end
      default: begin
      end
    endcase
  end

  // result payload
  always_comb begin
    out_nxt.status       = status_r;
    out_nxt.frame_valid  = status_r == plm_pkg::ST_OK;
    out_nxt.rise_valid   = rise_r;
    out_nxt.zero_count   = zc_r;
    out_nxt.low_level    = have_r ? low_r : '0;
    out_nxt.high_level   = have_r ? high_r : '0;
    out_nxt.amplitude    = amp_r;
    out_nxt.amplitude_mv = mv_r;
    out_nxt.t10_ps       = rise_r ? t10_r : '0;
    out_nxt.t90_ps       = rise_r ? t90_r : '0;
    out_nxt.rise_ps      = rise_r ? (t90_r - t10_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plm_pkg::S_LOAD;
      n_r         <= '0;
      tally_r     <= '0;
      ovf_r       <= 1'b0;
      div_sent_r  <= 1'b0;
      out_valid_r <= 1'b0;
      period_r    <= 20'd20000;
      fs_r        <= 14'd4000;
      adc_r       <= 14'd16383;
      lvl_r       <= 4'd8;
      zlim_r      <= 16'hFFFF;
      mina_r      <= 14'd20;
      eg_r        <= 11'd20;
      mrs_r       <= 13'd6;
    end else begin
      state_r <= state_nxt;
      if (div_start) begin
        div_sent_r <= 1'b1;
      end else if (div_done) begin
        div_sent_r <= 1'b0;
      end
      if ((state_r == plm_pkg::S_RESULT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == plm_pkg::S_RESULT) begin
        n_r     <= '0;
        tally_r <= '0;
        ovf_r   <= 1'b0;
      end else if (in_acc) begin
        if (has_room) begin
          n_r <= n_r + 1'b1;
          if (in_data.sample == '0) begin
            tally_r <= tally_r + 1'b1;
          end
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cfg_wr) begin
        unique case (plm_pkg::reg_idx_t'(paddr[4:2]))
          plm_pkg::REG_PERIOD:   period_r <= pwdata[19:0];
          plm_pkg::REG_FS:       fs_r     <= pwdata[13:0];
          plm_pkg::REG_ADC_MAX:  adc_r    <= pwdata[13:0];
          plm_pkg::REG_LEVEL:    lvl_r    <= pwdata[3:0];
          plm_pkg::REG_ZLIMIT:   zlim_r   <= pwdata[15:0];
          plm_pkg::REG_MIN_AMP:  mina_r   <= pwdata[13:0];
          plm_pkg::REG_GUARD:    eg_r     <= pwdata[10:0];
          plm_pkg::REG_MIN_SPAN: mrs_r    <= pwdata[12:0];
          default: begin
          end
        endcase
      end
    end
  end

  // analysis datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      plm_pkg::S_CHECK: begin
        status_r <= plm_pkg::ST_OK;
        have_r   <= 1'b0;
        rise_r   <= 1'b0;
        low_r    <= '0;
        high_r   <= '0;
        amp_r    <= '0;
        mv_r     <= '0;
        zc_r     <= '0;
        c_r      <= '0;
        if (ovf_r) begin
          status_r <= plm_pkg::ST_OVER;
        end else if (n_r < LW'(2)) begin
          status_r <= plm_pkg::ST_SHORT;
        end else begin
          zc_r <= plm_pkg::ZC_W'(tally_r);
          if ((zlim_r != plm_pkg::ZERO_OFF) && (32'(tally_r) > 32'(zlim_r))) begin
            status_r <= plm_pkg::ST_ZEROS;
          end
        end
      end
      plm_pkg::S_REPAIR: begin
        c_r <= c_r + 1'b1;
        x_r <= y_r;
        y_r <= rd;
      end
      plm_pkg::S_LVL: begin
        cnt_r  <= '0;
        lsum_r <= '0;
        hsum_r <= '0;
        if (lvl_bad || (s_fill == '0)) begin
          status_r <= plm_pkg::ST_NOLEVEL;
        end
      end
      plm_pkg::S_SUM: begin
        if (cnt_r != s_fill) begin
          cnt_r  <= cnt_r + 1'b1;
          lsum_r <= lsum_r + SUMW'(s_head);
          hsum_r <= hsum_r + SUMW'(l_head);
        end
      end
      plm_pkg::S_DLOW: if (div_done) low_r <= div_q[13:0];
      plm_pkg::S_DHIGH: begin
        if (div_done) begin
          high_r <= div_q[13:0];
          have_r <= 1'b1;
          if (div_q[13:0] <= low_r) begin
            status_r <= plm_pkg::ST_NOLEVEL;
          end
        end
      end
      plm_pkg::S_MAMP:  mul_r <= mul_a * mul_b;
      plm_pkg::S_DAMP:  if (div_done) amp_r <= div_q[13:0];
      plm_pkg::S_MMV:   mul_r <= mul_a * mul_b;
      plm_pkg::S_DMV: begin
        if (div_done) begin
          mv_r <= (div_q > plm_pkg::DIV_W'(plm_pkg::MV_MAX)) ? plm_pkg::MV_MAX
                                                              : div_q[15:0];
        end
      end
      plm_pkg::S_EVAL: begin
        c_r     <= '0;
        warm_r  <= '0;
        ph_r    <= 1'b0;
        drops_r <= '0;
        if (amp_r < mina_r) begin
          status_r <= plm_pkg::ST_SMALL;
        end
      end
      plm_pkg::S_SCAN: begin
        c_r    <= c_r + 1'b1;
        y_r    <= rd;
        warm_r <= (warm_r == 2'd2) ? 2'd2 : (warm_r + 2'd1);
        if (hit) begin
          diff_r <= th - ten0;
          den_r  <= ten1 - ten0;
          seg_r  <= LW'(j_idx);
          if (ph_r) begin
            c90_r <= LW'(j_idx);
          end else begin
            c10_r <= LW'(j_idx);
          end
        end else if ((warm_r == 2'd2) && ph_r && (rd < y_r)) begin
          drops_r <= drops_r + 1'b1;
        end
      end
      plm_pkg::S_MFRAC: mul_r <= mul_a * mul_b;
      plm_pkg::S_DFRAC: if (div_done) frac_r <= div_q;
      plm_pkg::S_MIDX:  mul_r <= mul_a * mul_b;
      plm_pkg::S_TADD: begin
        if (ph_r) begin
          t90_r <= tsat;
        end else begin
          t10_r   <= tsat;
          c_r     <= CW'(c10_r);
          warm_r  <= '0;
          ph_r    <= 1'b1;
          drops_r <= '0;
        end
      end
      plm_pkg::S_RISE:   rise_r <= rise_ok;
      plm_pkg::S_RESULT: if (out_free) out_r <= out_nxt;
      default: begin
      end
    endcase
  end

  always_comb begin
    prdata = '0;
    unique case (plm_pkg::reg_idx_t'(paddr[4:2]))
      plm_pkg::REG_PERIOD:   prdata = 32'(period_r);
      plm_pkg::REG_FS:       prdata = 32'(fs_r);
      plm_pkg::REG_ADC_MAX:  prdata = 32'(adc_r);
      plm_pkg::REG_LEVEL:    prdata = 32'(lvl_r);
      plm_pkg::REG_ZLIMIT:   prdata = 32'(zlim_r);
      plm_pkg::REG_MIN_AMP:  prdata = 32'(mina_r);
      plm_pkg::REG_GUARD:    prdata = 32'(eg_r);
      plm_pkg::REG_MIN_SPAN: prdata = 32'(mrs_r);
      default:               prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[tb/sv/pulse_meas_checker.sv]
module pulse_meas_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  plm_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  plm_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  input  logic          pready,
  output int            fail_count,
  output int            pending
);
  import plm_pkg::*;

  localparam int STORE_DEPTH = 4096;
  localparam int LEVEL_MAX = 8;

  logic [19:0] period;
  logic [13:0] full_scale, max_code, min_amp;
  logic [3:0]  lvl_cnt;
  logic [15:0] zlimit;
  logic [10:0] guard;
  logic [12:0] min_span;

  logic [13:0] frame_buf [STORE_DEPTH];
  int unsigned frame_len, zero_cnt;
  bit          overflowed;

  out_t expected_results [$];

  function automatic bit cross_at(input int unsigned n, input longint unsigned th,
                                  input int unsigned start, output int unsigned idx,
                                  output longint unsigned t);
    longint unsigned y0, y1, frac;
    for (int unsigned i = start; i + 1 < n; i++) begin
      y0 = frame_buf[i];
      y1 = frame_buf[i+1];
      if (y0 == 0 || y1 == 0 || y1 <= y0) continue;
      if (10*y0 <= th && 10*y1 >= th) begin
        frac = ((th - 10*y0) * period) / (10*(y1 - y0));
        t = longint'(i) * period + frac;
        if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        idx = i;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic out_t measure_frame();
    out_t r;
    int unsigned n, sfill, lfill, c10, c90, span, drops;
    longint unsigned lo, hi, amp, mv, t10, t90, ls, hs, th10, th90;
    logic [13:0] smin [LEVEL_MAX];
    logic [13:0] smax [LEVEL_MAX];
    logic [13:0] v;
    status_t st;
    bit rok, have;
    int unsigned p;
    n = frame_len; sfill = 0; lfill = 0;
    lo = 0; hi = 0; amp = 0; mv = 0; t10 = 0; t90 = 0;
    st = ST_OK; rok = 0; have = 0;
    r = '0;
    if (overflowed) begin
      r.status = ST_OVER;
      return r;
    end
    if (n < 2) begin
      r.status = ST_SHORT;
      return r;
    end
    r.zero_count = zero_cnt[12:0];
    if (zlimit != ZERO_OFF && zero_cnt > zlimit) begin
      r.status = ST_ZEROS;
      return r;
    end
    if (zero_cnt != 0)
      for (int unsigned i = 1; i + 1 < n; i++)
        if (frame_buf[i] == 0 && frame_buf[i-1] != 0 && frame_buf[i+1] != 0)
          frame_buf[i] = 14'((15'(frame_buf[i-1]) + 15'(frame_buf[i+1])) >> 1);
    if (lvl_cnt > LEVEL_MAX) st = ST_NOLEVEL;
    else begin
      for (int unsigned i = 0; i < n; i++) begin
        v = frame_buf[i];
        if (v == 0) continue;
        p = 0;
        while (p < sfill && !(v < smin[p])) p++;
        if (p < lvl_cnt) begin
          if (sfill < lvl_cnt) sfill++;
          for (int unsigned j = sfill - 1; j > p; j--) smin[j] = smin[j-1];
          smin[p] = v;
        end
        p = 0;
        while (p < lfill && !(v > smax[p])) p++;
        if (p < lvl_cnt) begin
          if (lfill < lvl_cnt) lfill++;
          for (int unsigned j = lfill - 1; j > p; j--) smax[j] = smax[j-1];
          smax[p] = v;
        end
      end
      if (sfill == 0 || lfill == 0) st = ST_NOLEVEL;
      else begin
        ls = 0; hs = 0;
        for (int unsigned i = 0; i < sfill; i++) ls += smin[i];
        for (int unsigned i = 0; i < lfill; i++) hs += smax[i];
        lo = ls / sfill;
        hi = hs / lfill;
        have = 1;
        if (hi <= lo) st = ST_NOLEVEL;
        else begin
          amp = ((hi - lo) * 96) / 100;
          if (max_code != 0) begin
            mv = (amp * full_scale) / max_code;
            if (mv > 65535) mv = 65535;
          end
          if (amp < min_amp) st = ST_SMALL;
        end
      end
    end
    if (st == ST_OK && period != 0 && n > 2*guard + 2) begin
      th10 = 10*lo + amp;
      th90 = 10*lo + 9*amp;
      if (cross_at(n, th10, 0, c10, t10) && cross_at(n, th90, c10, c90, t90)
          && c10 >= guard && c90 < n - guard - 1 && c90 > c10) begin
        span = c90 - c10 + 1;
        drops = 0;
        if (span >= min_span) begin
          for (int unsigned i = c10; i < c90; i++)
            if (frame_buf[i+1] < frame_buf[i]) drops++;
          if (drops <= span/4 && t90 > t10) rok = 1;
        end
      end
    end
    r.status = st;
    r.frame_valid = (st == ST_OK);
    r.rise_valid = rok;
    if (have) begin
      r.low_level = lo[13:0];
      r.high_level = hi[13:0];
    end
    r.amplitude = amp[13:0];
    r.amplitude_mv = mv[15:0];
    if (rok) begin
      r.t10_ps = t10[31:0];
      r.t90_ps = t90[31:0];
      r.rise_ps = 32'(t90 - t10);
    end
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      period <= 20000; full_scale <= 4000; max_code <= 16383; lvl_cnt <= 8;
      zlimit <= 16'hFFFF; min_amp <= 20; guard <= 20; min_span <= 6;
      frame_len = 0; zero_cnt = 0; overflowed = 0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready)
        case (reg_idx_t'(paddr[4:2]))
          REG_PERIOD:   period <= pwdata[19:0];
          REG_FS:       full_scale <= pwdata[13:0];
          REG_ADC_MAX:  max_code <= pwdata[13:0];
          REG_LEVEL:    lvl_cnt <= pwdata[3:0];
          REG_ZLIMIT:   zlimit <= pwdata[15:0];
          REG_MIN_AMP:  min_amp <= pwdata[13:0];
          REG_GUARD:    guard <= pwdata[10:0];
          REG_MIN_SPAN: min_span <= pwdata[12:0];
        endcase
      if (in_valid && !in_stall) begin
        if (frame_len < STORE_DEPTH) begin
          frame_buf[frame_len] = in_data.sample;
          frame_len++;
          if (in_data.sample == 0) zero_cnt++;
        end else overflowed = 1;
        if (in_data.last) begin
          expected_results.push_back(measure_frame());
          frame_len = 0; zero_cnt = 0; overflowed = 0;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            if (fail_count < 10) $display("mismatch exp %p got %p", want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/sv/tb_pulse_level_and_rise_time_measure.sv]
module tb_pulse_level_and_rise_time_measure;
  import plm_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_t in_data;
  out_t out_data;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending;
  int cycles;
  bit calm;
  int sent;

  pulse_level_and_rise_time_measure dut (.*);

  pulse_meas_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("tb_pulse_level_and_rise_time_measure: done, errors");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 0;
    else out_stall <= calm ? 1'b0 : ($urandom_range(99) < 17);
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_item(input logic [13:0] s, input logic lst);
    if (!calm)
      while ($urandom_range(99) < 17) begin
        in_valid <= 0;
        @(posedge clk);
      end
    in_valid <= 1;
    in_data <= '{sample: s, last: lst};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // edge with flat levels, random noise and optional zeros
  task automatic send_edge(input int n, input int lo, input int hi, input int zpct);
    int pos, w, v;
    pos = $urandom_range(n - 1);
    w = $urandom_range(12, 1);
    for (int i = 0; i < n; i++) begin
      if (i < pos) v = lo;
      else if (i >= pos + w) v = hi;
      else v = lo + (hi - lo) * (i - pos + 1) / (w + 1);
      v = v + $urandom_range(6) - 3;
      if (v < 1) v = 1;
      if (v > 16383) v = 16383;
      if ($urandom_range(99) < zpct) v = 0;
      send_item(14'(v), i == n - 1);
    end
  endtask

  task automatic random_config();
    reg_write(REG_PERIOD, $urandom_range(4) == 0 ? 1000000 : $urandom_range(50000, 1));
    reg_write(REG_FS, $urandom_range(10000, 1));
    reg_write(REG_ADC_MAX, $urandom_range(5) == 0 ? 0 : $urandom_range(16383, 1));
    reg_write(REG_LEVEL, $urandom_range(5) == 0 ? $urandom_range(15) : $urandom_range(8, 1));
    reg_write(REG_ZLIMIT, $urandom_range(2) == 0 ? 16'hFFFF : $urandom_range(4));
    reg_write(REG_MIN_AMP, $urandom_range(3) == 0 ? 16383 : $urandom_range(100));
    reg_write(REG_GUARD, $urandom_range(6) == 0 ? 2047 : $urandom_range(8));
    reg_write(REG_MIN_SPAN, $urandom_range(6) == 0 ? 4096 : $urandom_range(8));
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_data = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    calm = 0; sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: short, extremes, zeros, overflow
    send_item(14'h3FFF, 1);
    send_item(0, 0); send_item(0, 1);
    send_item(1, 0); send_item(0, 0); send_item(16383, 1);
    send_item(5, 0); send_item(5, 1);
    drain();
    reg_write(REG_GUARD, 2); reg_write(REG_MIN_SPAN, 2);
    reg_write(REG_LEVEL, 0);
    send_item(100, 0); send_item(200, 1);
    drain();
    reg_write(REG_LEVEL, 2); reg_write(REG_ZLIMIT, 0); reg_write(REG_MIN_AMP, 0);
    send_item(10, 0); send_item(0, 0); send_item(30, 1);
    drain();
    reg_write(REG_ZLIMIT, 16'hFFFF);
    send_edge(16, 100, 8000, 0);
    send_edge(16, 16383, 16383, 0);
    drain();
    calm = 1;
    for (int i = 0; i < 4097; i++) send_item(14'($urandom), i == 4096);
    calm = 0;
    drain();

    // random phases; most frames are noisy edges, some with zeros
    reg_write(REG_PERIOD, 20000); reg_write(REG_FS, 4000); reg_write(REG_ADC_MAX, 16383);
    reg_write(REG_LEVEL, 8); reg_write(REG_MIN_AMP, 20); reg_write(REG_GUARD, 3);
    reg_write(REG_MIN_SPAN, 2);
    while (sent < 4700) begin
      calm = ($urandom_range(9) == 0);
      repeat ($urandom_range(6, 2)) begin
        if ($urandom_range(4) == 0) begin
          int n;
          n = $urandom_range(6, 1);
          for (int i = 0; i < n; i++) send_item(14'($urandom), i == n - 1);
        end else
          send_edge($urandom_range(40, 8), $urandom_range(2000, 1),
                    $urandom_range(16383, 2000), $urandom_range(2) == 0 ? 0 : 8);
      end
      drain();
      random_config();
    end
    drain();
    if (fail_count == 0)
      $display("tb_pulse_level_and_rise_time_measure: done, clean");
    else
      $display("tb_pulse_level_and_rise_time_measure: done, errors");
    $finish;
  end
endmodule
